### rtl/ilsc_pkg.sv
// Shared types and constants for the IR learn-and-send sequencer.
`default_nettype none
package ilsc_pkg;

	// Event codes carried on the input stream
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_POLL  = 2'd1,
		OP_LEARN = 2'd2,
		OP_SEND  = 2'd3
	} op_t;

	// Internal mode register, one-hot
	typedef enum logic [6:0] {
		ST_NULL  = 7'b0000001,
		ST_FREE  = 7'b0000010,
		ST_LSTBY = 7'b0000100,
		ST_LEARN = 7'b0001000,
		ST_SSTBY = 7'b0010000,
		ST_SEND  = 7'b0100000,
		ST_STOP  = 7'b1000000
	} state_t;

	// Mode codes as they appear on the result stream
	localparam logic [2:0] MODE_NULL  = 3'd0;
	localparam logic [2:0] MODE_FREE  = 3'd1;
	localparam logic [2:0] MODE_LSTBY = 3'd2;
	localparam logic [2:0] MODE_LEARN = 3'd3;
	localparam logic [2:0] MODE_SSTBY = 3'd4;
	localparam logic [2:0] MODE_SEND  = 3'd5;
	localparam logic [2:0] MODE_STOP  = 3'd6;

	// Beep kinds
	localparam logic [1:0] BEEP_NONE = 2'd0;
	localparam logic [1:0] BEEP_WARN = 2'd1;
	localparam logic [1:0] BEEP_DONE = 2'd2;

	// Operation outcomes
	localparam logic [1:0] RES_NONE    = 2'd0;
	localparam logic [1:0] RES_LEARNED = 2'd1;
	localparam logic [1:0] RES_SENT    = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_STANDBY_TIMEOUT = 3'd0;
	localparam logic [2:0] REG_STANDBY_RETRIES = 3'd1;
	localparam logic [2:0] REG_LEARN_TIMEOUT   = 3'd2;
	localparam logic [2:0] REG_STOP_HOLD_TIME  = 3'd3;
	localparam logic [2:0] REG_WARN_THRESHOLD  = 3'd4;

	// Configuration reset values
	localparam logic [15:0] STANDBY_TIMEOUT_RST = 16'd1000;
	localparam logic [7:0]  STANDBY_RETRIES_RST = 8'd3;
	localparam logic [15:0] LEARN_TIMEOUT_RST   = 16'd20000;
	localparam logic [15:0] STOP_HOLD_TIME_RST  = 16'd1000;
	localparam logic [14:0] WARN_THRESHOLD_RST  = 15'd2000;

	// Countdown / 1000 as a multiply by ceil(2^26 / 1000), exact for 16-bit values
	localparam int          SEC_SHIFT = 26;
	localparam logic [16:0] SEC_RECIP = 17'd67109;

	// One result item
	typedef struct packed {
		logic [6:0] seconds_left;
		logic [1:0] op_result;
		logic [7:0] active_slot;
		logic [1:0] beep_kind;
		logic       issue_send;
		logic       issue_capture;
		logic       issue_learn_start;
		logic       reset_line;
		logic [2:0] mode;
	} result_t;

	// Mode code for the result stream
	function automatic logic [2:0] mode_code(state_t st);
		logic [2:0] code;
		unique case (st)
			ST_NULL:  code = MODE_NULL;
			ST_FREE:  code = MODE_FREE;
			ST_LSTBY: code = MODE_LSTBY;
			ST_LEARN: code = MODE_LEARN;
			ST_SSTBY: code = MODE_SSTBY;
			ST_SEND:  code = MODE_SEND;
			ST_STOP:  code = MODE_STOP;
			default:  code = MODE_FREE;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

### rtl/ir_learn_send_controller.sv
// IR learn-and-send sequencer: one command/status result per accepted request.
// The result of an accepted request is in the output register in the next cycle.
// Throughput: one request per cycle unless the output stalls; the state update and the
// seconds divide (a 16x17 reciprocal multiply) sit between state and result registers.
// The input is ready whenever the output register is empty or being drained.
// Reset: mode null, counters and output valid clear, config defaults, module reset released.
`default_nettype none
module ir_learn_send_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	// event stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [0] busy_pin, [8:1] slot_index, rest zero
	input  wire logic [1:0]  s_tuser,  // [1:0] opcode
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata   // [2:0] mode, [3] reset_line, [4] issue_learn_start,
	                                   // [5] issue_capture, [6] issue_send, [8:7] beep_kind,
	                                   // [16:9] active_slot, [18:17] op_result,
	                                   // [25:19] seconds_left, rest zero
);
	import ilsc_pkg::*;

	// configuration registers
	logic [15:0] standby_timeout_q;
	logic [7:0]  standby_retries_q;
	logic [15:0] learn_timeout_q;
	logic [15:0] stop_hold_time_q;
	logic [14:0] warn_threshold_q;

	// sequencer state
	state_t      mode_q;
	logic [15:0] cnt_q;
	logic [7:0]  retries_q;
	logic [7:0]  slot_q;
	logic        warned_q;
	logic [1:0]  result_q;
	logic        rst_lvl_q;

	// output register
	result_t     res_q;
	logic        out_valid_q;

	// next-state signals
	state_t      n_mode;
	logic [15:0] n_cnt;
	logic [7:0]  n_retries;
	logic [7:0]  n_slot;
	logic        n_warned;
	logic [1:0]  n_result;
	logic        n_rst_lvl;
	logic        ls;
	logic        cap;
	logic        snd;
	logic [1:0]  beep;
	logic [32:0] sec_prod;
	result_t     n_res;

	op_t         op;
	logic        busy;
	logic [7:0]  slot_in;
	logic        accept;

	assign op      = op_t'(s_tuser);
	assign busy    = s_tdata[0];
	assign slot_in = s_tdata[8:1];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			standby_timeout_q <= STANDBY_TIMEOUT_RST;
			standby_retries_q <= STANDBY_RETRIES_RST;
			learn_timeout_q   <= LEARN_TIMEOUT_RST;
			stop_hold_time_q  <= STOP_HOLD_TIME_RST;
			warn_threshold_q  <= WARN_THRESHOLD_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_STANDBY_TIMEOUT) standby_timeout_q <= cfg_wdata;
			if (cfg_index == REG_STANDBY_RETRIES) standby_retries_q <= cfg_wdata[7:0];
			if (cfg_index == REG_LEARN_TIMEOUT)   learn_timeout_q   <= cfg_wdata;
			if (cfg_index == REG_STOP_HOLD_TIME)  stop_hold_time_q  <= cfg_wdata;
			if (cfg_index == REG_WARN_THRESHOLD)  warn_threshold_q  <= cfg_wdata[14:0];
		end
	end

	// event handling
	always_comb begin
		n_mode    = mode_q;
		n_cnt     = cnt_q;
		n_retries = retries_q;
		n_slot    = slot_q;
		n_warned  = warned_q;
		n_result  = result_q;
		n_rst_lvl = rst_lvl_q;
		ls        = 1'b0;
		cap       = 1'b0;
		snd       = 1'b0;
		beep      = BEEP_NONE;
		unique case (op)
			OP_TICK: begin
				if (cnt_q != 16'd0) n_cnt = cnt_q - 16'd1;
			end
			OP_POLL: begin
				unique case (mode_q)
					ST_FREE: n_warned = 1'b0;
					ST_LSTBY: begin
						n_result = RES_NONE;
						if (retries_q == 8'd0) begin
							n_mode = ST_FREE;
						end else if (!busy) begin
							n_mode = ST_LEARN;
							n_cnt  = learn_timeout_q;
						end else if (cnt_q == 16'd0) begin
							ls        = 1'b1;
							n_cnt     = standby_timeout_q;
							n_retries = retries_q - 8'd1;
						end
					end
					ST_LEARN: begin
						if (cnt_q == 16'd0) begin
							// learn timed out: hold the module in reset
							n_rst_lvl = 1'b0;
							n_slot    = 8'd0;
							n_retries = 8'd0;
							n_cnt     = stop_hold_time_q;
							n_mode    = ST_STOP;
						end else if (busy) begin
							beep      = BEEP_DONE;
							n_cnt     = 16'd0;
							n_retries = 8'd0;
							cap       = 1'b1;
							n_mode    = ST_FREE;
							n_result  = RES_LEARNED;
						end else if (!warned_q && (cnt_q < {1'b0, warn_threshold_q})) begin
							n_warned = 1'b1;
							beep     = BEEP_WARN;
						end
					end
					ST_SSTBY: begin
						if (cnt_q == 16'd0) n_mode = ST_SEND;
					end
					ST_SEND: begin
						snd      = 1'b1;
						n_mode   = ST_FREE;
						n_result = RES_SENT;
					end
					ST_STOP: begin
						if (cnt_q == 16'd0) begin
							n_mode    = ST_FREE;
							n_rst_lvl = 1'b1;
						end
					end
					ST_NULL: n_mode = ST_FREE;
					default: n_mode = ST_FREE;
				endcase
			end
			OP_LEARN: begin
				n_rst_lvl = 1'b1;
				if (mode_q == ST_LEARN) begin
					n_cnt = learn_timeout_q;
				end else begin
					ls        = 1'b1;
					n_cnt     = standby_timeout_q;
					n_retries = standby_retries_q;
					n_mode    = ST_LSTBY;
					n_slot    = slot_in;
				end
			end
			OP_SEND: begin
				n_rst_lvl = 1'b1;
				n_slot    = slot_in;
				n_mode    = ST_SSTBY;
			end
			default: ;
		endcase
	end

	// seconds left: countdown / 1000 by reciprocal multiply
	assign sec_prod = 33'(n_cnt) * 33'(SEC_RECIP);

	always_comb begin
		n_res.mode              = mode_code(n_mode);
		n_res.reset_line        = n_rst_lvl;
		n_res.issue_learn_start = ls;
		n_res.issue_capture     = cap;
		n_res.issue_send        = snd;
		n_res.beep_kind         = beep;
		n_res.active_slot       = n_slot;
		n_res.op_result         = n_result;
		n_res.seconds_left      = sec_prod[SEC_SHIFT +: 7];
	end

	// state update on each accepted event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= ST_NULL;
			cnt_q     <= 16'd0;
			retries_q <= 8'd0;
			slot_q    <= 8'd0;
			warned_q  <= 1'b0;
			result_q  <= RES_NONE;
			rst_lvl_q <= 1'b1;
		end else if (accept) begin
			mode_q    <= n_mode;
			cnt_q     <= n_cnt;
			retries_q <= n_retries;
			slot_q    <= n_slot;
			warned_q  <= n_warned;
			result_q  <= n_result;
			rst_lvl_q <= n_rst_lvl;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) res_q <= n_res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_q};

`ifndef SYNTHESIS
	// at most one command strobe per result
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0({res_q.issue_learn_start, res_q.issue_capture,
			res_q.issue_send}))
		else $error("more than one command strobe in a result");

	// a capture always reports a learned code with the done beep
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.issue_capture) |->
			(res_q.beep_kind == BEEP_DONE && res_q.op_result == RES_LEARNED
			&& res_q.mode == MODE_FREE))
		else $error("capture without learned result");

	// module reset is only held while in stop mode
	a_reset_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res_q.reset_line) |-> (res_q.mode == MODE_STOP))
		else $error("module reset asserted outside stop mode");

	// an accepted event always yields a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted event produced no result");
`endif

endmodule
`default_nettype wire
